// ===== design/ca3d_pkg.sv =====
`timescale 1ns / 1ps

package ca3d_pkg;

  localparam int CRD_W     = 6;   // grid size and internal coordinates
  localparam int POS_W     = 5;   // request coordinates
  localparam int CNT_W     = 5;   // neighbor count, 0..26
  localparam int AGE_W     = 8;
  localparam int STAT_W    = 16;
  localparam int GEN_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 6;

  localparam logic [AGE_W-1:0]  AGE_MAX  = 8'd255;
  localparam logic [CNT_W-1:0]  NB_MAX   = 5'd26;
  localparam logic [CRD_W-1:0]  SIZE_MIN = 6'd3;
  localparam logic [STAT_W-1:0] STAT_MAX = 16'hFFFF;

  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_READ  = 2'd1,
    REQ_STEP  = 2'd2,
    REQ_CLEAR = 2'd3
  } req_code_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_SIZE    = 3'd0,
    CFG_BIRTH_LOW    = 3'd1,
    CFG_BIRTH_HIGH   = 3'd2,
    CFG_SURVIVE_LOW  = 3'd3,
    CFG_SURVIVE_HIGH = 3'd4,
    CFG_MOORE_MODE   = 3'd5,
    CFG_WRAP_EDGES   = 3'd6
  } cfg_index_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_ACCESS,
    ST_UPDATE,
    ST_PROBE,
    ST_PROBE_LAST,
    ST_CELL_WR,
    ST_COPY,
    ST_COPY_LAST,
    ST_RECOUNT,
    ST_RECOUNT_LAST,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic [CNT_W-1:0] birth_low;
    logic [CNT_W-1:0] birth_high;
    logic [CNT_W-1:0] survive_low;
    logic [CNT_W-1:0] survive_high;
  } rule_cfg_t;

  typedef struct packed {
    logic             nxt;
    logic             born;
    logic             died;
    logic [AGE_W-1:0] age;
  } rule_res_t;

endpackage

// ===== design/ca3d_if.sv =====
`timescale 1ns / 1ps

interface ca3d_req_if import ca3d_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       req_type;
  logic [POS_W-1:0] pos_x;
  logic [POS_W-1:0] pos_y;
  logic [POS_W-1:0] pos_z;
  logic             live_in;

  modport source (output valid, req_type, pos_x, pos_y, pos_z, live_in, input ready);
  modport sink   (input valid, req_type, pos_x, pos_y, pos_z, live_in, output ready);
endinterface

interface ca3d_res_if import ca3d_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              cell_live;
  logic [AGE_W-1:0]  cell_age;
  logic [STAT_W-1:0] birth_count;
  logic [STAT_W-1:0] death_count;
  logic [STAT_W-1:0] live_count;
  logic [GEN_W-1:0]  gen_number;

  modport source (output valid, cell_live, cell_age, birth_count, death_count, live_count,
                  gen_number, input ready);
  modport sink   (input valid, cell_live, cell_age, birth_count, death_count, live_count,
                  gen_number, output ready);
endinterface

interface ca3d_cfg_if import ca3d_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/ca3d_rule.sv =====
`timescale 1ns / 1ps

module ca3d_rule import ca3d_pkg::*; (
  input  rule_cfg_t        rule,
  input  logic [CNT_W-1:0] nb_cnt,
  input  logic             alive,
  input  logic [AGE_W-1:0] age,
  output rule_res_t        verdict
);

  logic keep;
  logic birth_ok;

  always_comb begin
    keep     = (nb_cnt >= rule.survive_low) && (nb_cnt <= rule.survive_high);
    birth_ok = (nb_cnt >= rule.birth_low) && (nb_cnt <= rule.birth_high);
    verdict.nxt  = alive ? keep : birth_ok;
    verdict.born = !alive && birth_ok;
    verdict.died = alive && !keep;
    if (!verdict.nxt) begin
      verdict.age = '0;
    end else if (!alive) begin
      verdict.age = AGE_W'(1);
    end else if (age == AGE_MAX) begin
      verdict.age = age;
    end else begin
      verdict.age = age + 1'b1;
    end
  end

endmodule

// ===== design/cellular_automaton_3d_life_like_top.sv =====
`timescale 1ns / 1ps

// 3D life-like automaton over a cube of up to MAX_GRID cells per axis.
// Channels: req (write, read, step, clear), res (one result per request),
// cfg (register writes, index = register number, taken only when idle).
// State sits in three single-port-read synchronous RAMs: live bits, next bits
// and 8-bit ages.
// A write or read inside the cube goes through access and update; outside it goes
// straight to the result. A step computes next bits for every cell of the cube
// in use, then copies the next bits into the live bits. A clear zeroes every
// live-bit and age RAM entry (MAX_GRID^3).
// A step walks 27 probe positions per cell, one live-bit RAM read each, so
// the live-bit read port sets the step time.
// Writing grid_size recounts the live cells of the new cube, during which no
// request or register write is taken.
// Reset runs a clearing pass over all MAX_GRID^3 entries (one per cycle)
// before the first request is taken; registers return to their defaults.
// The result sits in an output register; a new request may be taken while it
// waits. A stalled receiver holds the result and the next one waits behind it.
module cellular_automaton_3d_life_like_top import ca3d_pkg::*; #(
  parameter int MAX_GRID = 32
) (
  input logic      clk,
  input logic      rst,
  ca3d_cfg_if.sink cfg,
  ca3d_req_if.sink req,
  ca3d_res_if.source res
);

  localparam int CELLS = MAX_GRID * MAX_GRID * MAX_GRID;
  localparam int AW    = $clog2(CELLS);
  localparam int TOT_W = AW + 1;
  localparam logic [CRD_W:0]   MAX_G     = (CRD_W + 1)'(MAX_GRID);
  localparam logic [AW-1:0]    LAST_CELL = AW'(CELLS - 1);

  // ---------------------------------------------------------------- helpers
  function automatic logic [AW-1:0] cell_addr(input logic [CRD_W-1:0] x,
                                              input logic [CRD_W-1:0] y,
                                              input logic [CRD_W-1:0] z);
    logic [31:0] a;
    a = (32'(z) * 32'(MAX_GRID) + 32'(y)) * 32'(MAX_GRID) + 32'(x);
    return a[AW-1:0];
  endfunction

  // one axis of a neighbor offset: {in range, coordinate}
  function automatic logic [CRD_W:0] nb_axis(input logic [CRD_W-1:0] c,
                                             input logic [1:0]       d,
                                             input logic [CRD_W-1:0] s,
                                             input logic             wrap);
    logic [CRD_W:0]   v;
    logic             ok;
    logic [CRD_W-1:0] o;
    v = {1'b0, c} + {{(CRD_W - 1){1'b0}}, d};
    if (v == '0) begin
      ok = wrap;
      o  = s - 1'b1;
    end else if (v > {1'b0, s}) begin
      ok = wrap;
      o  = '0;
    end else begin
      ok = 1'b1;
      o  = v[CRD_W-1:0] - 1'b1;
    end
    return {ok, o};
  endfunction

  function automatic logic [STAT_W-1:0] sat16(input logic [TOT_W-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return (w > 32'(STAT_MAX)) ? STAT_MAX : w[STAT_W-1:0];
  endfunction

  // ---------------------------------------------------------------- registers
  state_t state, state_next;

  logic [CRD_W-1:0] grid_size;
  rule_cfg_t        rule;
  logic             moore_mode;
  logic             wrap_edges;

  logic [GEN_W-1:0]  gen_counter;
  logic [TOT_W-1:0]  live_total;
  logic [STAT_W-1:0] last_births;
  logic [STAT_W-1:0] last_deaths;
  logic [TOT_W-1:0]  births;
  logic [TOT_W-1:0]  deaths;
  logic [TOT_W-1:0]  total_acc;

  logic [AW-1:0]    lin;
  logic [CRD_W-1:0] cx, cy, cz;
  logic [1:0]       dx, dy, dz;
  logic [CNT_W-1:0] nb_cnt;
  logic             alive;
  logic             probe_cnt_q;
  logic             probe_ctr_q;
  logic             copy_v_q;
  logic [AW-1:0]    copy_addr_q;
  logic             rc_v_q;

  logic [1:0]       r_type;
  logic [POS_W-1:0] r_x, r_y, r_z;
  logic             r_live;
  logic             clr_reply;
  logic             res_live_q;
  logic [AGE_W-1:0] res_age_q;

  // ---------------------------------------------------------------- memories
  logic             live_mem [CELLS];
  logic             next_mem [CELLS];
  logic [AGE_W-1:0] age_mem  [CELLS];

  logic             live_rd, next_rd;
  logic [AGE_W-1:0] age_rd;

  logic             live_we, next_we, age_we;
  logic [AW-1:0]    live_waddr, live_raddr, next_waddr, next_raddr, age_waddr, age_raddr;
  logic             live_wdata, next_wdata;
  logic [AGE_W-1:0] age_wdata;

  always_ff @(posedge clk) begin
    if (live_we) begin
      live_mem[live_waddr] <= live_wdata;
    end
    live_rd <= live_mem[live_raddr];
  end

  always_ff @(posedge clk) begin
    if (next_we) begin
      next_mem[next_waddr] <= next_wdata;
    end
    next_rd <= next_mem[next_raddr];
  end

  always_ff @(posedge clk) begin
    if (age_we) begin
      age_mem[age_waddr] <= age_wdata;
    end
    age_rd <= age_mem[age_raddr];
  end

  // ---------------------------------------------------------------- datapath
  logic [CRD_W-1:0] size_use;
  logic             req_fire, cfg_fire, res_load;
  logic             req_inside;
  logic [AW-1:0]    cell_a, req_a, nb_a;
  logic [CRD_W:0]   ax, ay, az;
  logic             probe_ok, probe_center, last_probe, last_cell;
  logic [1:0]       off_axes;
  rule_res_t        verdict;

  always_comb begin
    if (grid_size < SIZE_MIN) begin
      size_use = SIZE_MIN;
    end else if ({1'b0, grid_size} > MAX_G) begin
      size_use = MAX_G[CRD_W-1:0];
    end else begin
      size_use = grid_size;
    end
  end

  assign req.ready = (state == ST_IDLE) && !cfg.valid;
  assign cfg.ready = (state == ST_IDLE);
  assign req_fire  = req.valid && req.ready;
  assign cfg_fire  = cfg.valid && cfg.ready;
  assign res_load  = !res.valid || res.ready;

  assign req_inside = ({1'b0, req.pos_x} < size_use) && ({1'b0, req.pos_y} < size_use) &&
                      ({1'b0, req.pos_z} < size_use);

  assign cell_a = cell_addr(cx, cy, cz);
  assign req_a  = cell_addr(CRD_W'(r_x), CRD_W'(r_y), CRD_W'(r_z));

  assign ax   = nb_axis(cx, dx, size_use, wrap_edges);
  assign ay   = nb_axis(cy, dy, size_use, wrap_edges);
  assign az   = nb_axis(cz, dz, size_use, wrap_edges);
  assign nb_a = cell_addr(ax[CRD_W-1:0], ay[CRD_W-1:0], az[CRD_W-1:0]);

  assign probe_center = (dx == 2'd1) && (dy == 2'd1) && (dz == 2'd1);
  assign off_axes     = 2'(dx != 2'd1) + 2'(dy != 2'd1) + 2'(dz != 2'd1);
  // Moore: all but the center; von Neumann: exactly one axis offset
  assign probe_ok = ax[CRD_W] && ay[CRD_W] && az[CRD_W] &&
                    (moore_mode ? !probe_center : (off_axes == 2'd1));
  assign last_probe = (dx == 2'd2) && (dy == 2'd2) && (dz == 2'd2);
  assign last_cell  = (cx == size_use - 1'b1) && (cy == size_use - 1'b1) &&
                      (cz == size_use - 1'b1);

  ca3d_rule u_rule (
    .rule    (rule),
    .nb_cnt  (nb_cnt),
    .alive   (alive),
    .age     (age_rd),
    .verdict (verdict)
  );

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_fire) begin
          case (req.req_type)
            REQ_WRITE, REQ_READ: state_next = req_inside ? ST_ACCESS : ST_RESULT;
            REQ_STEP:            state_next = ST_PROBE;
            REQ_CLEAR:           state_next = ST_CLEAR;
            default:             state_next = ST_IDLE;
          endcase
        end else if (cfg_fire && (cfg.index == CFG_GRID_SIZE)) begin
          state_next = ST_RECOUNT;
        end
      end
      ST_CLEAR: begin
        if (lin == LAST_CELL) begin
          state_next = clr_reply ? ST_RESULT : ST_IDLE;
        end
      end
      ST_ACCESS:     state_next = ST_UPDATE;
      ST_UPDATE:     state_next = ST_RESULT;
      ST_PROBE:      state_next = last_probe ? ST_PROBE_LAST : ST_PROBE;
      ST_PROBE_LAST: state_next = ST_CELL_WR;
      ST_CELL_WR:    state_next = last_cell ? ST_COPY : ST_PROBE;
      ST_COPY:       state_next = last_cell ? ST_COPY_LAST : ST_COPY;
      ST_COPY_LAST:  state_next = ST_RESULT;
      ST_RECOUNT:    state_next = last_cell ? ST_RECOUNT_LAST : ST_RECOUNT;
      ST_RECOUNT_LAST: state_next = ST_IDLE;
      ST_RESULT:     state_next = res_load ? ST_IDLE : ST_RESULT;
      default:       state_next = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- memory controls
  always_comb begin
    live_we    = 1'b0;
    live_waddr = copy_addr_q;
    live_wdata = next_rd;
    live_raddr = req_a;
    age_we     = 1'b0;
    age_waddr  = req_a;
    age_wdata  = verdict.age;
    age_raddr  = req_a;
    next_we    = 1'b0;
    next_waddr = cell_a;
    next_wdata = verdict.nxt;
    next_raddr = cell_a;
    // each copy write lands in the cycle after its read
    if (copy_v_q) begin
      live_we = 1'b1;
    end
    case (state)
      ST_CLEAR: begin
        live_we    = 1'b1;
        live_waddr = lin;
        live_wdata = 1'b0;
        age_we     = 1'b1;
        age_waddr  = lin;
        age_wdata  = '0;
      end
      ST_UPDATE: begin
        if (r_type == REQ_WRITE) begin
          live_we    = 1'b1;
          live_waddr = req_a;
          live_wdata = r_live;
          age_we     = 1'b1;
          age_wdata  = AGE_W'(r_live);
        end
      end
      ST_PROBE, ST_PROBE_LAST: begin
        live_raddr = nb_a;
        age_raddr  = cell_a;
      end
      ST_CELL_WR: begin
        age_raddr = cell_a;
        age_we    = 1'b1;
        age_waddr = cell_a;
        next_we   = 1'b1;
      end
      ST_RECOUNT: live_raddr = cell_a;
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      grid_size   <= CRD_W'(32);
      rule        <= '{birth_low: 5'd5, birth_high: 5'd7, survive_low: 5'd4,
                       survive_high: 5'd6};
      moore_mode  <= 1'b1;
      wrap_edges  <= 1'b1;
      gen_counter <= '0;
      live_total  <= '0;
      last_births <= '0;
      last_deaths <= '0;
      lin         <= '0;
      clr_reply   <= 1'b0;
      probe_cnt_q <= 1'b0;
      probe_ctr_q <= 1'b0;
      copy_v_q    <= 1'b0;
      rc_v_q      <= 1'b0;
      res.valid   <= 1'b0;
    end else begin
      state       <= state_next;
      probe_cnt_q <= (state == ST_PROBE) && probe_ok;
      probe_ctr_q <= (state == ST_PROBE) && probe_center;
      copy_v_q    <= (state == ST_COPY);
      rc_v_q      <= (state == ST_RECOUNT);

      if (cfg_fire) begin
        case (cfg.index)
          CFG_GRID_SIZE:    grid_size         <= cfg.data;
          CFG_BIRTH_LOW:    rule.birth_low    <= cfg.data[CNT_W-1:0];
          CFG_BIRTH_HIGH:   rule.birth_high   <= cfg.data[CNT_W-1:0];
          CFG_SURVIVE_LOW:  rule.survive_low  <= cfg.data[CNT_W-1:0];
          CFG_SURVIVE_HIGH: rule.survive_high <= cfg.data[CNT_W-1:0];
          CFG_MOORE_MODE:   moore_mode        <= cfg.data[0];
          CFG_WRAP_EDGES:   wrap_edges        <= cfg.data[0];
          default: ;
        endcase
      end

      if (req_fire && (req.req_type == REQ_CLEAR)) begin
        gen_counter <= '0;
        live_total  <= '0;
        clr_reply   <= 1'b1;
        lin         <= '0;
      end
      if (state == ST_CLEAR) begin
        lin <= lin + 1'b1;
      end

      if ((state == ST_UPDATE) && (r_type == REQ_WRITE)) begin
        if (live_rd && !r_live) begin
          live_total <= live_total - 1'b1;
        end else if (!live_rd && r_live) begin
          live_total <= live_total + 1'b1;
        end
      end

      if (state == ST_COPY_LAST) begin
        gen_counter <= gen_counter + 1'b1;
        last_births <= sat16(births);
        last_deaths <= sat16(deaths);
        live_total  <= total_acc;
      end

      if (state == ST_RECOUNT_LAST) begin
        live_total <= total_acc + TOT_W'(rc_v_q && live_rd);
      end

      if ((state == ST_RESULT) && res_load) begin
        res.valid <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- sweep and payload registers
  always_ff @(posedge clk) begin
    if (req_fire) begin
      r_type     <= req.req_type;
      r_x        <= req.pos_x;
      r_y        <= req.pos_y;
      r_z        <= req.pos_z;
      r_live     <= req.live_in;
      res_live_q <= 1'b0;
      res_age_q  <= '0;
    end

    // cube walk shared by step, copy and recount
    if ((req_fire && (req.req_type == REQ_STEP)) ||
        (cfg_fire && (cfg.index == CFG_GRID_SIZE)) ||
        ((state == ST_CELL_WR) && last_cell)) begin
      cx <= '0;
      cy <= '0;
      cz <= '0;
    end else if (((state == ST_CELL_WR) || (state == ST_COPY) || (state == ST_RECOUNT)) &&
                 !last_cell) begin
      if (cx == size_use - 1'b1) begin
        cx <= '0;
        if (cy == size_use - 1'b1) begin
          cy <= '0;
          cz <= cz + 1'b1;
        end else begin
          cy <= cy + 1'b1;
        end
      end else begin
        cx <= cx + 1'b1;
      end
    end

    // probe offsets, base 3 per axis
    if (state == ST_PROBE) begin
      if (dx == 2'd2) begin
        dx <= '0;
        if (dy == 2'd2) begin
          dy <= '0;
          dz <= dz + 1'b1;
        end else begin
          dy <= dy + 1'b1;
        end
      end else begin
        dx <= dx + 1'b1;
      end
    end else begin
      dx <= '0;
      dy <= '0;
      dz <= '0;
    end

    if (state == ST_CELL_WR) begin
      nb_cnt <= '0;
    end else if (probe_cnt_q && live_rd) begin
      nb_cnt <= nb_cnt + 1'b1;
    end
    if (req_fire) begin
      nb_cnt <= '0;
    end
    if (probe_ctr_q) begin
      alive <= live_rd;
    end

    if ((req_fire && (req.req_type == REQ_STEP)) ||
        (cfg_fire && (cfg.index == CFG_GRID_SIZE))) begin
      births    <= '0;
      deaths    <= '0;
      total_acc <= '0;
    end else if (state == ST_CELL_WR) begin
      births    <= births + TOT_W'(verdict.born);
      deaths    <= deaths + TOT_W'(verdict.died);
      total_acc <= total_acc + TOT_W'(verdict.nxt);
    end else if (rc_v_q && live_rd) begin
      total_acc <= total_acc + 1'b1;
    end

    copy_addr_q <= cell_a;

    if ((state == ST_UPDATE) && (r_type == REQ_READ)) begin
      res_live_q <= live_rd;
      res_age_q  <= age_rd;
    end

    if ((state == ST_RESULT) && res_load) begin
      res.cell_live   <= res_live_q;
      res.cell_age    <= res_age_q;
      res.birth_count <= last_births;
      res.death_count <= last_deaths;
      res.live_count  <= sat16(live_total);
      res.gen_number  <= gen_counter;
    end
  end

  // ---------------------------------------------------------------- assertions
  a_nb_cnt_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CELL_WR) |-> (nb_cnt <= NB_MAX))
    else $error("neighbor count above 26");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RESULT) && res.valid && !res.ready |=> (state == ST_RESULT))
    else $error("result left pending state while output register was full");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !live_we && !age_we && !next_we)
    else $error("memory write while idle");

  a_gen_change: assert property (@(posedge clk) disable iff (rst)
    (gen_counter != $past(gen_counter)) |->
      ($past(state) == ST_COPY_LAST) || ($past(state) == ST_IDLE))
    else $error("generation counter moved outside step end or clear");

endmodule
